[design/adsr_pkg.sv]
`timescale 1ns / 1ps

package adsr_pkg;

    localparam int GAIN_W  = 18;
    localparam int RATE_W  = 16;
    localparam int MOD_W   = 16;
    localparam int STEP_W  = 17;
    localparam int PROD_W  = RATE_W + MOD_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_RELEASE = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_RATE   = 3'd0,
        REG_DECAY_RATE    = 3'd1,
        REG_RELEASE_RATE  = 3'd2,
        REG_PEAK_LEVEL    = 3'd3,
        REG_SUSTAIN_LEVEL = 3'd4
    } cfg_idx_t;

    localparam logic [RATE_W-1:0] ATTACK_RATE_RST  = 16'd655;
    localparam logic [RATE_W-1:0] DECAY_RATE_RST   = 16'd655;
    localparam logic [RATE_W-1:0] RELEASE_RATE_RST = 16'd655;
    localparam logic [GAIN_W-1:0] PEAK_LEVEL_RST   = 18'd65536;
    localparam logic [GAIN_W-1:0] SUSTAIN_LEVEL_RST = 18'd32768;

endpackage

[design/adsr_if.sv]
`timescale 1ns / 1ps

interface adsr_tick_if;
    import adsr_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [MOD_W-1:0] mod_factor;

    modport source (output valid, output cmd, output mod_factor, input ready);
    modport sink (input valid, input cmd, input mod_factor, output ready);
endinterface

interface adsr_result_if;
    import adsr_pkg::*;

    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;
    logic [1:0]        phase_now;

    modport source (output valid, output gain, output phase_now, input ready);
    modport sink (input valid, input gain, input phase_now, output ready);
endinterface

interface adsr_cfg_if;
    import adsr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/adsr_envelope_generator.sv]
`timescale 1ns / 1ps

// ADSR envelope generator. Each tick transaction either advances the envelope by one
// audio sample (cmd = 0) or retriggers it to gain 0 in attack (cmd = 1), and produces
// exactly one result transaction with the new gain (unsigned Q2.16) and phase. The
// block is a two-stage pipeline: the first stage registers the tick together with
// both rate-times-modulation products, the second does the add, clamp and phase
// decision and loads the result register, which also holds the envelope state. A
// new tick is accepted every cycle unless stage one is full and the result is held;
// the result register keeps its transaction while the next tick is already taken.
// Configuration writes are always accepted and take effect on the next cycle.
module adsr_envelope_generator (
    input  logic                  clk,
    input  logic                  rst_n,
    adsr_tick_if.sink             tick,
    adsr_result_if.source         result,
    adsr_cfg_if.sink              cfg
);
    import adsr_pkg::*;

    logic [RATE_W-1:0] attack_rate_reg;
    logic [RATE_W-1:0] decay_rate_reg;
    logic [RATE_W-1:0] release_rate_reg;
    logic [GAIN_W-1:0] peak_level_reg;
    logic [GAIN_W-1:0] sustain_level_reg;

    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [STEP_W-1:0] s1_att_step_reg;
    logic [STEP_W-1:0] s1_dec_step_reg;

    logic              out_valid_reg;
    logic [GAIN_W-1:0] gain_reg;
    phase_t            phase_reg;

    logic              out_free;
    logic              s1_advance;
    logic              tick_accept;
    logic [PROD_W-1:0] att_prod;
    logic [PROD_W-1:0] dec_prod;

    logic [GAIN_W:0]   att_sum;
    logic [GAIN_W-1:0] att_sat;
    logic [GAIN_W-1:0] gain_next;
    phase_t            phase_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_rate_reg   <= ATTACK_RATE_RST;
            decay_rate_reg    <= DECAY_RATE_RST;
            release_rate_reg  <= RELEASE_RATE_RST;
            peak_level_reg    <= PEAK_LEVEL_RST;
            sustain_level_reg <= SUSTAIN_LEVEL_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ATTACK_RATE:   attack_rate_reg   <= cfg.data[RATE_W-1:0];
                REG_DECAY_RATE:    decay_rate_reg    <= cfg.data[RATE_W-1:0];
                REG_RELEASE_RATE:  release_rate_reg  <= cfg.data[RATE_W-1:0];
                REG_PEAK_LEVEL:    peak_level_reg    <= cfg.data[GAIN_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg.data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign tick.ready  = !s1_valid_reg || out_free;
    assign tick_accept = tick.valid && tick.ready;

    // Both products are formed up front; the phase picks one in the next stage.
    assign att_prod = PROD_W'(attack_rate_reg) * PROD_W'(tick.mod_factor);
    assign dec_prod = PROD_W'(decay_rate_reg) * PROD_W'(tick.mod_factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            s1_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_cmd_reg      <= tick.cmd;
            s1_att_step_reg <= att_prod[PROD_W-1:PROD_W-STEP_W];
            s1_dec_step_reg <= dec_prod[PROD_W-1:PROD_W-STEP_W];
        end
    end

    assign att_sum = {1'b0, gain_reg} + (GAIN_W+1)'(s1_att_step_reg);
    assign att_sat = att_sum[GAIN_W] ? GAIN_MAX : att_sum[GAIN_W-1:0];

    always_comb
    begin
        gain_next  = gain_reg;
        phase_next = phase_reg;
        if (s1_cmd_reg)
        begin
            gain_next  = '0;
            phase_next = PH_ATTACK;
        end
        else
        begin
            case (phase_reg)
                PH_ATTACK:
                begin
                    if (att_sat >= peak_level_reg)
                    begin
                        gain_next  = peak_level_reg;
                        phase_next = PH_DECAY;
                    end
                    else
                    begin
                        gain_next = att_sat;
                    end
                end
                PH_DECAY:
                begin
                    // A step larger than the gain would go negative, which is below
                    // any sustain level.
                    if ((GAIN_W+1)'(gain_reg) <= (GAIN_W+1)'(sustain_level_reg)
                        + (GAIN_W+1)'(s1_dec_step_reg))
                    begin
                        gain_next  = sustain_level_reg;
                        phase_next = PH_RELEASE;
                    end
                    else
                    begin
                        gain_next = gain_reg - GAIN_W'(s1_dec_step_reg);
                    end
                end
                PH_RELEASE:
                begin
                    if (gain_reg <= GAIN_W'(release_rate_reg))
                    begin
                        gain_next  = '0;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        gain_next = gain_reg - GAIN_W'(release_rate_reg);
                    end
                end
                PH_IDLE:
                begin
                    gain_next = gain_reg;
                end
                default:
                begin
                    gain_next  = gain_reg;
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // The result register doubles as the envelope state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            gain_reg      <= '0;
            phase_reg     <= PH_ATTACK;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_advance)
            begin
                gain_reg  <= gain_next;
                phase_reg <= phase_next;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.gain      = gain_reg;
    assign result.phase_now = phase_reg;

`ifndef ASSERT_OFF
    a_retrigger_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_cmd_reg) |=> (gain_reg == '0 && phase_reg == PH_ATTACK))
        else $error("retrigger did not clear the envelope");

    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (gain_reg == '0))
        else $error("idle phase with nonzero gain");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (s1_valid_reg && out_valid_reg && !result.ready))
        else $error("tick stalled while the pipeline had room");

    a_result_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a registered tick");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> ($stable(gain_reg) && $stable(phase_reg)))
        else $error("envelope state changed without a tick");
`endif

endmodule
